### hdl/pac_pkg.sv
// Shared constants, types and command/status structs of the polygon area and centroid block.
package pac_pkg;

  localparam int CoordW      = 16;
  localparam int AreaW       = 44;
  localparam int MomW        = 62;
  localparam int AreaOutW    = 42;
  localparam int CenW        = 24;
  localparam int MaxFracBits = 8;

  localparam int MaxVerticesDef = 1024;
  localparam int CoordWidthDef  = 16;
  localparam int FracBitsDef    = 8;

  typedef struct packed {
    logic capture;
    logic set_first;
    logic sat_count;
    logic closing;
    logic mul;
    logic xprod;
    logic mom;
    logic acc;
    logic advance;
    logic div_init;
    logic div_step;
    logic finish;
  } pac_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic last;
    logic div_done;
  } pac_sts_t;

endpackage

### hdl/pac_intf.sv
// Valid/ready channel interfaces for vertices and results.
interface pac_vertex_if;
  logic                            valid;
  logic                            ready;
  logic signed [pac_pkg::CoordW-1:0] vertex_x;
  logic signed [pac_pkg::CoordW-1:0] vertex_y;
  logic                            last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface pac_result_if;
  logic                              valid;
  logic                              ready;
  logic [pac_pkg::AreaOutW-1:0]      area_twice;
  logic signed [pac_pkg::CenW-1:0]   centroid_x;
  logic signed [pac_pkg::CenW-1:0]   centroid_y;
  logic                              degenerate;
  logic                              overflow;

  modport source (output valid, output area_twice, output centroid_x, output centroid_y,
                  output degenerate, output overflow, input ready);
  modport sink   (input valid, input area_twice, input centroid_x, input centroid_y,
                  input degenerate, input overflow, output ready);
endinterface

### hdl/polygon_area_centroid_core.sv
// Top level of the streaming shoelace polygon area and centroid block.
//
//   channel | dir | payload
//   vtx_i   | in  | vertex_x, vertex_y, last_vertex
//   res_o   | out | area_twice, centroid_x, centroid_y, degenerate, overflow
//
// A vertex that opens a polygon or is dropped passes through the idle and load states;
// one that adds an edge also runs a four-step edge sequence (two multiply stages).
// The last vertex adds a closing edge and a restoring division: a load step, one
// quotient bit per cycle and a done check, then the result stage.
// The result sits in an output register; a stalled result holds the next polygon's
// result in the datapath until the transfer. Reset clears all sums and control at once.
module polygon_area_centroid_core #(
  parameter int MAX_VERTICES = pac_pkg::MaxVerticesDef,
  parameter int COORD_WIDTH  = pac_pkg::CoordWidthDef,
  parameter int FRAC_BITS    = pac_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pac_vertex_if.sink    vtx_i,
  pac_result_if.source  res_o
);
  import pac_pkg::*;

  pac_cmd_t cmd;
  pac_sts_t sts;

  pac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vtx_i.valid),
    .in_ready_o  (vtx_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pac_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vertex_x_i    (vtx_i.vertex_x),
    .vertex_y_i    (vtx_i.vertex_y),
    .last_vertex_i (vtx_i.last_vertex),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .area_twice_o  (res_o.area_twice),
    .centroid_x_o  (res_o.centroid_x),
    .centroid_y_o  (res_o.centroid_y),
    .degenerate_o  (res_o.degenerate),
    .overflow_o    (res_o.overflow)
  );
endmodule

### hdl/pac_ctrl.sv
// Controller state machine sequencing vertex intake, edge steps, division and result transfer.
module pac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pac_pkg::pac_sts_t sts_i,
  output pac_pkg::pac_cmd_t cmd_o
);
  import pac_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StLoad  = 8'b0000_0010,
    StMul   = 8'b0000_0100,
    StCross = 8'b0000_1000,
    StMom   = 8'b0001_0000,
    StAcc   = 8'b0010_0000,
    StDiv   = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } pac_state_e;

  pac_state_e state_q, state_d;
  logic       closing_q, closing_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    closing_d  = closing_q;
    cmd_o      = '0;
    cmd_o.closing = closing_q;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLoad;
        end
      end
      StLoad: begin
        if (sts_i.cnt_full || sts_i.cnt_zero) begin
          cmd_o.sat_count = sts_i.cnt_full;
          cmd_o.set_first = !sts_i.cnt_full;
          closing_d       = 1'b1;
          state_d         = sts_i.last ? StMul : StIdle;
        end else begin
          closing_d = 1'b0;
          state_d   = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StCross;
      end
      StCross: begin
        cmd_o.xprod = 1'b1;
        state_d     = StMom;
      end
      StMom: begin
        cmd_o.mom = 1'b1;
        state_d   = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        if (closing_q) begin
          state_d = StDiv;
        end else begin
          cmd_o.advance = 1'b1;
          closing_d     = 1'b1;
          state_d       = sts_i.last ? StMul : StIdle;
        end
      end
      StDiv: begin
        if (closing_q) begin
          cmd_o.div_init = 1'b1;
          closing_d      = 1'b0;
        end else if (sts_i.div_done) begin
          state_d = StDone;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      closing_q   <= closing_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

### hdl/pac_dp.sv
// Datapath: vertex registers, shoelace edge arithmetic, accumulators and centroid dividers.
module pac_dp #(
  parameter int MAX_VERTICES = pac_pkg::MaxVerticesDef,
  parameter int COORD_WIDTH  = pac_pkg::CoordWidthDef,
  parameter int FRAC_BITS    = pac_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [pac_pkg::CoordW-1:0]  vertex_x_i,
  input  logic signed [pac_pkg::CoordW-1:0]  vertex_y_i,
  input  logic                               last_vertex_i,
  input  pac_pkg::pac_cmd_t                  cmd_i,
  output pac_pkg::pac_sts_t                  sts_o,
  output logic [pac_pkg::AreaOutW-1:0]       area_twice_o,
  output logic signed [pac_pkg::CenW-1:0]    centroid_x_o,
  output logic signed [pac_pkg::CenW-1:0]    centroid_y_o,
  output logic                               degenerate_o,
  output logic                               overflow_o
);
  import pac_pkg::*;

  localparam int CntW  = $clog2(MAX_VERTICES + 2);
  localparam int NumW  = MomW + FRAC_BITS;
  localparam int DenW  = AreaW + 2;
  localparam int QW    = CenW + 1;
  localparam int DcntW = $clog2(NumW + 1);
  localparam int CrW   = 2 * CoordW + 1;
  localparam int MxW   = CrW + CoordW + 1;
  localparam logic [QW-1:0] LimPos = QW'((1 << (CenW - 1)) - 1);
  localparam logic [QW-1:0] LimNeg = QW'(1 << (CenW - 1));

  logic signed [CoordW-1:0]     cur_x_q, cur_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic                         last_q;
  logic [CntW-1:0]              cnt_q;
  logic signed [2*CoordW-1:0]   p1_q, p2_q;
  logic signed [CoordW:0]       sx_q, sy_q;
  logic signed [CrW-1:0]        cross_q;
  logic signed [MxW-1:0]        mx_q, my_q;
  logic signed [AreaW-1:0]      area_q;
  logic signed [MomW-1:0]       msx_q, msy_q;
  logic [NumW-1:0]              nx_q, ny_q;
  logic [DenW-1:0]              rx_q, ry_q, d_q;
  logic [QW-1:0]                qx_q, qy_q;
  logic                         ox_q, oy_q, negx_q, negy_q;
  logic [DcntW-1:0]             dcnt_q;

  logic signed [COORD_WIDTH-1:0] tx, ty;
  logic signed [CoordW-1:0]      x1, y1;
  logic [AreaW-1:0]              area_abs;
  logic [MomW-1:0]               mx_abs, my_abs;
  logic [DenW:0]                 rx_sh, ry_sh;
  logic                          bx, by;

  assign tx = vertex_x_i[COORD_WIDTH-1:0];
  assign ty = vertex_y_i[COORD_WIDTH-1:0];
  assign x1 = cmd_i.closing ? first_x_q : cur_x_q;
  assign y1 = cmd_i.closing ? first_y_q : cur_y_q;
  assign area_abs = area_q[AreaW-1] ? AreaW'(-area_q) : AreaW'(area_q);
  assign mx_abs   = msx_q[MomW-1] ? MomW'(-msx_q) : MomW'(msx_q);
  assign my_abs   = msy_q[MomW-1] ? MomW'(-msy_q) : MomW'(msy_q);
  assign rx_sh = {rx_q, nx_q[NumW-1]};
  assign ry_sh = {ry_q, ny_q[NumW-1]};
  assign bx = rx_sh >= {1'b0, d_q};
  assign by = ry_sh >= {1'b0, d_q};

  assign sts_o.cnt_zero = cnt_q == '0;
  assign sts_o.cnt_full = cnt_q >= CntW'(MAX_VERTICES);
  assign sts_o.last     = last_q;
  assign sts_o.div_done = dcnt_q == '0;

  function automatic logic [CenW-1:0] sat_q(input logic [QW-1:0] q, input logic ovf,
                                            input logic neg);
    logic [QW-1:0] lim;
    logic [QW-1:0] m;
    lim = neg ? LimNeg : LimPos;
    m   = (ovf || q > lim) ? lim : q;
    return neg ? CenW'(-m) : CenW'(m);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      area_q    <= '0;
      msx_q     <= '0;
      msy_q     <= '0;
      dcnt_q    <= '0;
    end else begin
      if (cmd_i.sat_count) begin
        cnt_q <= CntW'(MAX_VERTICES + 1);
      end
      if (cmd_i.set_first) begin
        first_x_q <= cur_x_q;
        first_y_q <= cur_y_q;
        prev_x_q  <= cur_x_q;
        prev_y_q  <= cur_y_q;
        cnt_q     <= CntW'(1);
      end
      if (cmd_i.advance) begin
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
        cnt_q    <= cnt_q + CntW'(1);
      end
      if (cmd_i.mom) begin
        area_q <= area_q + AreaW'(cross_q);
      end
      if (cmd_i.acc) begin
        msx_q <= msx_q + MomW'(mx_q);
        msy_q <= msy_q + MomW'(my_q);
      end
      if (cmd_i.div_init) begin
        dcnt_q <= DcntW'(NumW);
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - DcntW'(1);
      end
      if (cmd_i.finish) begin
        cnt_q     <= '0;
        first_x_q <= '0;
        first_y_q <= '0;
        prev_x_q  <= '0;
        prev_y_q  <= '0;
        area_q    <= '0;
        msx_q     <= '0;
        msy_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_x_q <= CoordW'(tx);
      cur_y_q <= CoordW'(ty);
      last_q  <= last_vertex_i;
    end
    if (cmd_i.mul) begin
      p1_q <= prev_x_q * y1;
      p2_q <= prev_y_q * x1;
      sx_q <= (CoordW+1)'(prev_x_q) + (CoordW+1)'(x1);
      sy_q <= (CoordW+1)'(prev_y_q) + (CoordW+1)'(y1);
    end
    if (cmd_i.xprod) begin
      cross_q <= CrW'(p1_q) - CrW'(p2_q);
    end
    if (cmd_i.mom) begin
      mx_q <= sx_q * cross_q;
      my_q <= sy_q * cross_q;
    end
    if (cmd_i.div_init) begin
      nx_q   <= NumW'(mx_abs) << FRAC_BITS;
      ny_q   <= NumW'(my_abs) << FRAC_BITS;
      d_q    <= (DenW'(area_abs) << 1) + DenW'(area_abs);
      rx_q   <= '0;
      ry_q   <= '0;
      qx_q   <= '0;
      qy_q   <= '0;
      ox_q   <= 1'b0;
      oy_q   <= 1'b0;
      negx_q <= msx_q[MomW-1] ^ area_q[AreaW-1];
      negy_q <= msy_q[MomW-1] ^ area_q[AreaW-1];
    end else if (cmd_i.div_step) begin
      nx_q <= nx_q << 1;
      ny_q <= ny_q << 1;
      rx_q <= bx ? DenW'(rx_sh - {1'b0, d_q}) : DenW'(rx_sh);
      ry_q <= by ? DenW'(ry_sh - {1'b0, d_q}) : DenW'(ry_sh);
      qx_q <= {qx_q[QW-2:0], bx};
      qy_q <= {qy_q[QW-2:0], by};
      ox_q <= ox_q | qx_q[QW-1];
      oy_q <= oy_q | qy_q[QW-1];
    end
    if (cmd_i.finish) begin
      area_twice_o <= AreaOutW'(area_abs);
      degenerate_o <= area_q == '0;
      overflow_o   <= cnt_q > CntW'(MAX_VERTICES);
      centroid_x_o <= (area_q == '0) ? '0 : sat_q(qx_q, ox_q, negx_q);
      centroid_y_o <= (area_q == '0) ? '0 : sat_q(qy_q, oy_q, negy_q);
    end
  end
endmodule
